FILE: hdl/enos_pkg.sv
// Shared constants and types for the display record name override stream.
package enos_pkg;

  localparam int          QUEUE_DEPTH      = 2;
  localparam int          CFG_INDEX_W      = 2;
  localparam int          CFG_DATA_W       = 64;

  localparam logic [3:0]  NAME_LEN         = 4'd13;
  // The closing byte of the tag sequence must sit at position 54 + 3 or later.
  localparam logic [6:0]  MATCH_FROM_POS   = 7'd57;
  localparam logic [6:0]  LAST_POS         = 7'd127;
  localparam logic [7:0]  DESC_TAG         = 8'hFC;

  localparam logic [63:0] NAME_FIRST_RESET = 64'h202020646E65776F;
  localparam logic [39:0] NAME_REST_RESET  = 40'h2020202020;

  localparam logic [CFG_INDEX_W-1:0] REG_NAME_FIRST = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_NAME_REST  = CFG_INDEX_W'(1);

  typedef enum logic [1:0] {
    ACT_PASS,
    ACT_NAME,
    ACT_CHECKSUM
  } act_t;

  typedef struct packed {
    act_t       act;
    logic [7:0] data;
    logic [3:0] name_idx;
    logic       found;
  } item_t;

endpackage

FILE: hdl/enos_front.sv
// Front end: accepts record bytes, tracks position and finds the name descriptor tag.
module enos_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      data_byte,
  input  logic            queue_full,
  output logic            push,
  output enos_pkg::item_t push_item
);

  logic [7:0] recent [3];
  logic [6:0] pos;
  logic       match_seen;
  logic [3:0] replace_left;

  logic       match_seen_next;
  logic [3:0] replace_left_next;
  logic       tag_hit;

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  assign tag_hit = !match_seen && (pos >= enos_pkg::MATCH_FROM_POS) &&
                   (recent[2] == 8'h00) && (recent[1] == 8'h00) &&
                   (recent[0] == enos_pkg::DESC_TAG) && (data_byte == 8'h00);

  always_comb begin
    push_item.data     = data_byte;
    push_item.name_idx = 4'd0;
    match_seen_next    = match_seen;
    replace_left_next  = replace_left;
    if (pos == enos_pkg::LAST_POS) begin
      push_item.act   = enos_pkg::ACT_CHECKSUM;
      push_item.found = match_seen;
    end else begin
      if (replace_left != 4'd0) begin
        push_item.act      = enos_pkg::ACT_NAME;
        push_item.name_idx = enos_pkg::NAME_LEN - replace_left;
        replace_left_next  = replace_left - 4'd1;
      end else begin
        push_item.act = enos_pkg::ACT_PASS;
      end
      if (tag_hit) begin
        match_seen_next   = 1'b1;
        replace_left_next = enos_pkg::NAME_LEN;
      end
      push_item.found = match_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recent[0]    <= 8'h00;
      recent[1]    <= 8'h00;
      recent[2]    <= 8'h00;
      pos          <= 7'd0;
      match_seen   <= 1'b0;
      replace_left <= 4'd0;
    end else if (push) begin
      if (pos == enos_pkg::LAST_POS) begin
        // End of record: everything starts over for the next one.
        recent[0]    <= 8'h00;
        recent[1]    <= 8'h00;
        recent[2]    <= 8'h00;
        pos          <= 7'd0;
        match_seen   <= 1'b0;
        replace_left <= 4'd0;
      end else begin
        recent[0]    <= data_byte;
        recent[1]    <= recent[0];
        recent[2]    <= recent[1];
        pos          <= pos + 7'd1;
        match_seen   <= match_seen_next;
        replace_left <= replace_left_next;
      end
    end
  end

  a_replace_needs_match: assert property (@(posedge clk) disable iff (rst)
    (replace_left != 4'd0) |-> match_seen)
    else $error("name replacement pending without a descriptor match");

  a_record_wraps: assert property (@(posedge clk) disable iff (rst)
    (push && pos == enos_pkg::LAST_POS) |=> (pos == 7'd0 && !match_seen &&
                                             replace_left == 4'd0))
    else $error("record state not cleared after the checksum byte");

  a_no_early_match: assert property (@(posedge clk) disable iff (rst)
    (pos < enos_pkg::MATCH_FROM_POS) |-> !match_seen)
    else $error("descriptor match before the search window");

endmodule

FILE: hdl/enos_queue.sv
// Small request queue between the classifying front end and the output back end.
module enos_queue #(
  parameter int Depth = enos_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  enos_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output enos_pkg::item_t head_item
);

  localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountW = $clog2(Depth + 1);

  enos_pkg::item_t   mem [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CountW-1:0] count;

  assign full      = (count == CountW'(Depth));
  assign not_empty = (count != CountW'(0));
  assign head_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CountW'(1);
        2'b01:   count <= count - CountW'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("request pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    !not_empty |-> !pop)
    else $error("request popped from an empty queue");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(Depth))
    else $error("queue count beyond its depth");

endmodule

FILE: hdl/enos_back.sv
// Back end: name registers, output byte selection, running checksum and output register.
module enos_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  wr_en,
  input  logic [enos_pkg::CFG_INDEX_W-1:0]      wr_index,
  input  logic [enos_pkg::CFG_DATA_W-1:0]       wr_data,
  input  logic                                  not_empty,
  input  enos_pkg::item_t                       head_item,
  output logic                                  pop,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [7:0]                            out_byte,
  output logic                                  replaced,
  output logic                                  found,
  output logic                                  last
);

  logic [63:0] name_first;
  logic [39:0] name_rest;
  logic [7:0]  running_sum;
  logic [7:0]  name_sel;
  logic [7:0]  byte_next;

  assign pop = not_empty && (!out_valid || !out_stall);

  always_comb begin
    if (!head_item.name_idx[3]) begin
      name_sel = name_first[{head_item.name_idx[2:0], 3'b000} +: 8];
    end else if (head_item.name_idx[2:0] <= 3'd4) begin
      name_sel = name_rest[{head_item.name_idx[2:0], 3'b000} +: 8];
    end else begin
      name_sel = 8'h00;
    end
    case (head_item.act)
      enos_pkg::ACT_NAME:     byte_next = name_sel;
      enos_pkg::ACT_CHECKSUM: byte_next = 8'h00 - running_sum;
      default:                byte_next = head_item.data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      name_first <= enos_pkg::NAME_FIRST_RESET;
      name_rest  <= enos_pkg::NAME_REST_RESET;
    end else if (wr_en) begin
      case (wr_index)
        enos_pkg::REG_NAME_FIRST: name_first <= wr_data;
        enos_pkg::REG_NAME_REST:  name_rest  <= wr_data[39:0];
        default:                  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      running_sum <= 8'h00;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        if (head_item.act == enos_pkg::ACT_CHECKSUM) begin
          running_sum <= 8'h00;
        end else begin
          running_sum <= running_sum + byte_next;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte <= byte_next;
      replaced <= (head_item.act == enos_pkg::ACT_NAME);
      found    <= head_item.found;
      last     <= (head_item.act == enos_pkg::ACT_CHECKSUM);
    end
  end

  a_sum_clears_after_last: assert property (@(posedge clk) disable iff (rst)
    (pop && head_item.act == enos_pkg::ACT_CHECKSUM) |=> (running_sum == 8'h00))
    else $error("checksum accumulator not cleared at end of record");

  a_replaced_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(replaced && last))
    else $error("checksum byte marked as a name byte");

  a_pop_fills_output: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid)
    else $error("popped request did not reach the output register");

endmodule

FILE: hdl/edid_name_override_stream.sv
// Top level of the display record name override stream.
// An accepted byte passes through the request queue and then the output register.
// Throughput: one byte per cycle; during an output stall the two-entry request queue
// takes one more request, and the input stalls once the queue is full.
// Reset clears the record position, tag search, checksum, queue and output valid,
// and loads the name registers with their default string.
module edid_name_override_stream #(
  parameter int QueueDepth = enos_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       data_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_byte,
  output logic                             replaced,
  output logic                             found,
  output logic                             last,
  input  logic                             wr_en,
  input  logic [enos_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [enos_pkg::CFG_DATA_W-1:0]  wr_data
);

  logic            push;
  logic            queue_full;
  logic            pop;
  logic            not_empty;
  enos_pkg::item_t push_item;
  enos_pkg::item_t head_item;

  enos_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  enos_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (not_empty),
    .head_item (head_item)
  );

  enos_back u_back (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .not_empty (not_empty),
    .head_item (head_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .replaced  (replaced),
    .found     (found),
    .last      (last)
  );

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the display record name override stream.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [enos_pkg::CFG_INDEX_W-1:0] REG_SPARE_2 = enos_pkg::CFG_INDEX_W'(2);
  localparam logic [enos_pkg::CFG_INDEX_W-1:0] REG_SPARE_3 = enos_pkg::CFG_INDEX_W'(3);
  localparam int RECORD_LEN = 128;

  typedef struct packed {
    logic [7:0] data;
    logic       rep;
    logic       fnd;
    logic       lst;
  } out_byte_t;

  typedef enum logic [1:0] {
    BG_ZERO,
    BG_ONES,
    BG_RANDOM,
    BG_TAGGY
  } bg_style_t;

  class override_tracker;
    logic [63:0] name_first;
    logic [39:0] name_rest;
    logic [7:0]  recent [3];
    logic [6:0]  pos;
    logic        match_seen;
    logic [3:0]  replace_left;
    logic [7:0]  sum;
    out_byte_t   pending_bytes [$];
    int          errors;
    int          n_checked;
    int          n_records;
    int          n_named_records;
    int          n_replaced;

    function new();
      name_first = enos_pkg::NAME_FIRST_RESET;
      name_rest  = enos_pkg::NAME_REST_RESET;
      errors = 0;
      n_checked = 0;
      n_records = 0;
      n_named_records = 0;
      n_replaced = 0;
      clear_record();
    endfunction

    function void clear_record();
      recent[0] = 8'h00;
      recent[1] = 8'h00;
      recent[2] = 8'h00;
      pos = 7'd0;
      match_seen = 1'b0;
      replace_left = 4'd0;
      sum = 8'h00;
    endfunction

    function void set_reg(logic [enos_pkg::CFG_INDEX_W-1:0] idx, logic [63:0] val);
      case (idx)
        enos_pkg::REG_NAME_FIRST: name_first = val;
        enos_pkg::REG_NAME_REST:  name_rest = val[39:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_bytes.size();
    endfunction

    function void note_request(logic [7:0] din);
      out_byte_t r;
      int k;
      if (pos == enos_pkg::LAST_POS) begin
        r.data = 8'(8'd0 - sum);
        r.rep = 1'b0;
        r.fnd = match_seen;
        r.lst = 1'b1;
        clear_record();
      end else begin
        if (replace_left != 4'd0) begin
          k = int'(enos_pkg::NAME_LEN) - int'(replace_left);
          r.data = (k < 8) ? name_first[8*k +: 8] : name_rest[8*(k-8) +: 8];
          r.rep = 1'b1;
          replace_left = replace_left - 4'd1;
        end else begin
          r.data = din;
          r.rep = 1'b0;
        end
        // Only the first tag sequence closing at or after the search start counts.
        if (!match_seen && pos >= enos_pkg::MATCH_FROM_POS && recent[2] == 8'h00 &&
            recent[1] == 8'h00 && recent[0] == enos_pkg::DESC_TAG && din == 8'h00) begin
          match_seen = 1'b1;
          replace_left = enos_pkg::NAME_LEN;
        end
        sum = sum + r.data;
        recent[2] = recent[1];
        recent[1] = recent[0];
        recent[0] = din;
        pos = pos + 7'd1;
        r.fnd = match_seen;
        r.lst = 1'b0;
      end
      pending_bytes.push_back(r);
    endfunction

    function void check_output(logic [7:0] ob, logic rep, logic fnd, logic lst);
      out_byte_t e;
      if (pending_bytes.size() == 0) begin
        $display("%0t: output byte %h arrived with no request pending", $time, ob);
        errors++;
        return;
      end
      e = pending_bytes.pop_front();
      n_checked++;
      if (ob !== e.data) begin
        $display("%0t: out_byte expected %h actual %h", $time, e.data, ob);
        errors++;
      end
      if (rep !== e.rep) begin
        $display("%0t: replaced expected %b actual %b", $time, e.rep, rep);
        errors++;
      end
      if (fnd !== e.fnd) begin
        $display("%0t: found expected %b actual %b", $time, e.fnd, fnd);
        errors++;
      end
      if (lst !== e.lst) begin
        $display("%0t: last expected %b actual %b", $time, e.lst, lst);
        errors++;
      end
      if (e.rep) n_replaced++;
      if (e.lst) begin
        n_records++;
        if (e.fnd) n_named_records++;
      end
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             in_valid;
  logic                             in_stall;
  logic [7:0]                       data_byte;
  logic                             out_valid;
  logic                             out_stall;
  logic [7:0]                       out_byte;
  logic                             replaced;
  logic                             found;
  logic                             last;
  logic                             wr_en;
  logic [enos_pkg::CFG_INDEX_W-1:0] wr_index;
  logic [enos_pkg::CFG_DATA_W-1:0]  wr_data;

  override_tracker tracker;
  logic [7:0] rec [RECORD_LEN];
  int send_idle_pct;
  int recv_idle_pct;

  edid_name_override_stream dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .replaced(replaced),
    .found(found),
    .last(last),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      tracker.check_output(out_byte, replaced, found, last);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_request(b);
    @(negedge clk);
  endtask

  task automatic send_span(input int from, input int upto);
    for (int i = from; i <= upto; i++) send_byte(rec[i]);
  endtask

  // Lets every outstanding request come out, then adds a margin of idle time.
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [enos_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [63:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(negedge clk);
    wr_en <= 1'b0;
    tracker.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic write_names(input logic [63:0] first, input logic [63:0] rest);
    write_reg(enos_pkg::REG_NAME_FIRST, first);
    write_reg(enos_pkg::REG_NAME_REST, rest);
    write_reg(REG_SPARE_2, {$urandom, $urandom});
    write_reg(REG_SPARE_3, {$urandom, $urandom});
  endtask

  task automatic fill_background(input bg_style_t style);
    int pick;
    for (int i = 0; i < RECORD_LEN; i++) begin
      case (style)
        BG_ZERO:   rec[i] = 8'h00;
        BG_ONES:   rec[i] = 8'hFF;
        BG_RANDOM: rec[i] = 8'($urandom);
        default: begin
          pick = $urandom_range(3);
          rec[i] = (pick == 0) ? 8'h00 : (pick == 1) ? enos_pkg::DESC_TAG : 8'($urandom);
        end
      endcase
    end
  endtask

  task automatic place_tag(input int p);
    rec[p] = 8'h00;
    rec[p+1] = 8'h00;
    rec[p+2] = enos_pkg::DESC_TAG;
    rec[p+3] = 8'h00;
  endtask

  task automatic build_random_record();
    int kind;
    int p;
    kind = $urandom_range(9);
    fill_background(bg_style_t'($urandom_range(3)));
    if (kind <= 6) begin
      place_tag($urandom_range(124, 50));
      if ($urandom_range(1)) place_tag($urandom_range(124, 54));
    end else if (kind <= 8) begin
      // A tag sequence with one byte spoiled.
      p = $urandom_range(124, 50);
      place_tag(p);
      rec[p + $urandom_range(3)] ^= 8'($urandom_range(255, 1));
    end
  endtask

  task automatic random_records(input int count);
    for (int n = 0; n < count; n++) begin
      build_random_record();
      send_span(0, RECORD_LEN - 1);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = 8'h00;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    send_idle_pct = 18;
    recv_idle_pct = 59;
    tracker = new();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Tags that start before the search window are ignored; the valid one late in
    // the record runs its name into the checksum byte.
    fill_background(BG_ONES);
    place_tag(50);
    place_tag(53);
    place_tag(90);
    rec[93] = 8'h01;
    place_tag(112);
    send_span(0, RECORD_LEN - 1);

    // Earliest valid tag, then a second one that must not restart the name.
    fill_background(BG_ZERO);
    place_tag(54);
    place_tag(80);
    send_span(0, RECORD_LEN - 1);

    fill_background(BG_RANDOM);
    place_tag(123);
    send_span(0, RECORD_LEN - 1);

    // The closing byte lands on the checksum position and is not seen.
    fill_background(BG_RANDOM);
    place_tag(124);
    send_span(0, RECORD_LEN - 1);

    // Name fills positions up to the checksum exactly.
    fill_background(BG_ONES);
    place_tag(110);
    send_span(0, RECORD_LEN - 1);

    drain();
    write_names('1, '1);
    random_records(1);

    drain();
    send_idle_pct = 59;
    recv_idle_pct = 18;
    write_names('0, '0);
    random_records(1);

    // Change the name halfway through a replacement.
    fill_background(BG_TAGGY);
    place_tag(56);
    send_span(0, 65);
    drain();
    write_names({$urandom, $urandom}, {$urandom, $urandom});
    send_span(66, RECORD_LEN - 1);

    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_names({$urandom, $urandom}, {$urandom, $urandom});
    random_records(1);

    drain();
    repeat (10) @(negedge clk);
    if (tracker.pending() != 0) begin
      $display("%0t: %0d expected output bytes never arrived", $time, tracker.pending());
      tracker.errors++;
    end
    $display("Checked %0d output bytes over %0d records, %0d with a name descriptor found,",
             tracker.n_checked, tracker.n_records, tracker.n_named_records);
    $display("%0d bytes replaced, under three stall patterns and five name settings.",
             tracker.n_replaced);
    if (tracker.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
